// ===== design/modinv_pkg.sv =====
`timescale 1ns / 1ps

package modinv_pkg;

   // Sequencer states of the extended Euclid controller.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ALIGN,
      ST_DIV_A,
      ST_DIV_B,
      ST_UPDATE,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic align_shift;
      logic div_step;
      logic acc_step;
      logic shift_down;
      logic update;
      logic emit;
   } cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic r_zero;
      logic can_shift;
      logic last_bit;
   } stat_type;

endpackage

// ===== design/modinv_ctrl.sv =====
`timescale 1ns / 1ps

module modinv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_start,
   input  modinv_pkg::stat_type stat,
   output modinv_pkg::cmd_type  cmd,
   output logic                busy
);
   import modinv_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_start) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = stat.r_zero ? ST_DONE : ST_ALIGN;
         end
         ST_ALIGN: begin
            state_in = stat.can_shift ? ST_ALIGN : ST_DIV_A;
         end
         ST_DIV_A: begin
            state_in = ST_DIV_B;
         end
         ST_DIV_B: begin
            state_in = stat.last_bit ? ST_UPDATE : ST_DIV_A;
         end
         ST_UPDATE: begin
            state_in = ST_CHECK;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_start;
         end
         ST_ALIGN: begin
            cmd.align_shift = stat.can_shift;
         end
         ST_DIV_A: begin
            cmd.div_step = 1'b1;
         end
         ST_DIV_B: begin
            cmd.acc_step   = 1'b1;
            cmd.shift_down = !stat.last_bit;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         ST_DONE: begin
            cmd.emit = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== design/modinv_datapath.sv =====
`timescale 1ns / 1ps

module modinv_datapath #(
   parameter int WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  modinv_pkg::cmd_type  cmd,
   output modinv_pkg::stat_type stat,
   input  logic [WIDTH-1:0]     req_value,
   input  logic [WIDTH-1:0]     req_modulus,
   output logic                 rsp_strobe,
   output logic [WIDTH-1:0]     rsp_inverse,
   output logic                 rsp_has_inverse,
   output logic [WIDTH-1:0]     rsp_common_divisor
);
   import modinv_pkg::*;

   localparam int CW = $clog2(WIDTH);
   localparam logic [WIDTH-1:0] ONE = {{(WIDTH-1){1'b0}}, 1'b1};

   logic [WIDTH-1:0] old_r_ff, r_ff, rem_ff, div_ff;
   logic [WIDTH-1:0] old_t_ff, t_ff, prod_ff, m_ff;
   logic [CW-1:0]    cnt_ff;
   logic             bit_ff;
   logic             strobe_ff;
   logic [WIDTH-1:0] inverse_ff, gcd_ff;
   logic             has_ff;

   logic [WIDTH:0]   dbl_sum, acc_sum, m_ext;
   logic [WIDTH-1:0] dbl_val, acc_val, sub_val, rem_diff, t_init;
   logic             rem_ge, has_in;

   // Modular doubling and addition; both operands stay below the modulus.
   assign m_ext   = {1'b0, m_ff};
   assign dbl_sum = {prod_ff, 1'b0};
   assign dbl_val = (dbl_sum >= m_ext) ? WIDTH'(dbl_sum - m_ext) : WIDTH'(dbl_sum);
   assign acc_sum = {1'b0, prod_ff} + {1'b0, t_ff};
   assign acc_val = (acc_sum >= m_ext) ? WIDTH'(acc_sum - m_ext) : WIDTH'(acc_sum);
   // Modular subtraction, wrapping at the word width.
   assign sub_val = old_t_ff - prod_ff + ((old_t_ff < prod_ff) ? m_ff : '0);

   assign rem_ge   = (rem_ff >= div_ff);
   assign rem_diff = rem_ff - div_ff;
   assign t_init   = {{(WIDTH-1){1'b0}}, (req_modulus != ONE)};
   assign has_in   = (old_r_ff == ONE) && (m_ff != '0);

   assign stat.r_zero    = (r_ff == '0);
   assign stat.can_shift = !div_ff[WIDTH-1] && ({div_ff[WIDTH-2:0], 1'b0} <= rem_ff);
   assign stat.last_bit  = (cnt_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         old_r_ff <= req_modulus;
         r_ff     <= req_value;
         old_t_ff <= '0;
         t_ff     <= t_init;
         m_ff     <= req_modulus;
         rem_ff   <= req_modulus;
         div_ff   <= req_value;
         prod_ff  <= '0;
         cnt_ff   <= '0;
      end else if (cmd.update) begin
         old_r_ff <= r_ff;
         r_ff     <= rem_ff;
         old_t_ff <= t_ff;
         t_ff     <= sub_val;
         rem_ff   <= r_ff;
         div_ff   <= rem_ff;
         prod_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         if (cmd.align_shift) begin
            div_ff <= {div_ff[WIDTH-2:0], 1'b0};
            cnt_ff <= cnt_ff + 1'b1;
         end
         if (cmd.div_step) begin
            if (rem_ge) begin
               rem_ff <= rem_diff;
            end
            bit_ff  <= rem_ge;
            prod_ff <= dbl_val;
         end
         if (cmd.acc_step && bit_ff) begin
            prod_ff <= acc_val;
         end
         if (cmd.shift_down) begin
            div_ff <= {1'b0, div_ff[WIDTH-1:1]};
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
      if (cmd.emit) begin
         has_ff     <= has_in;
         inverse_ff <= has_in ? old_t_ff : '0;
         gcd_ff     <= old_r_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.emit;
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_inverse        = inverse_ff;
   assign rsp_has_inverse    = has_ff;
   assign rsp_common_divisor = gcd_ff;

endmodule

// ===== design/modular_inverse.sv =====
`timescale 1ns / 1ps

// Modular inverse by the extended Euclidean algorithm. A word is taken when
// req_start is high and busy is low; busy then stays high until the result
// has been formed, and the result word appears on the rsp_ ports for exactly
// one cycle with rsp_strobe high. The receiver cannot hold results off, so it
// must take every strobed word as it comes. One word is worked on at a time.
// Each Euclid step is a restoring shift-and-subtract division in which the
// quotient bits, as they appear, drive a modular double-and-add that builds
// the quotient times the current coefficient. A step first shifts the divisor
// up until it lines up with the dividend, then forms one quotient bit at a
// time, each in a subtract state and an accumulate state, and ends with an
// update of the remainders and the coefficients. The shift counts add up to
// roughly WIDTH over a run.
module modular_inverse #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_start,
   output logic             busy,
   input  logic [WIDTH-1:0] req_value,
   input  logic [WIDTH-1:0] req_modulus,
   output logic             rsp_strobe,
   output logic [WIDTH-1:0] rsp_inverse,
   output logic             rsp_has_inverse,
   output logic [WIDTH-1:0] rsp_common_divisor
);
   import modinv_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // The controller sequences load, alignment, division and update steps.
   modinv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_start (req_start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy)
   );

   // The datapath holds the remainders, the coefficients and the result word.
   modinv_datapath #(
      .WIDTH (WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_value          (req_value),
      .req_modulus        (req_modulus),
      .rsp_strobe         (rsp_strobe),
      .rsp_inverse        (rsp_inverse),
      .rsp_has_inverse    (rsp_has_inverse),
      .rsp_common_divisor (rsp_common_divisor)
   );

   // A result word only follows a cycle in which the block was working.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without preceding work");

   // An inverse is reported only when the divisor is one.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_has_inverse) |-> (rsp_common_divisor == {{(WIDTH-1){1'b0}}, 1'b1}))
      else $error("inverse reported with divisor other than one");

   // Without an inverse the inverse field reads zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_has_inverse) |-> (rsp_inverse == '0))
      else $error("nonzero inverse without inverse flag");

   // An accepted word makes the block busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_start && !busy) |=> busy)
      else $error("accepted word did not start work");

endmodule

// ===== verif/modular_inverse_test.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the extended Euclid modular inverse. An initial block
// builds a queue of operand words: a directed set of corner cases first, then a
// mixed random population. A clocked driver presents them in bursts separated by
// random gaps. A clocked monitor predicts each accepted word and checks every
// strobed result against the oldest prediction, field by field.
module modular_inverse_test;

   localparam int WIDTH       = 32;
   localparam int RANDOM_WORDS = 400;
   localparam int IDLE_LIMIT  = 4000;   // cycles with no handshake before giving up
   localparam int SETTLE_WAIT = 600;    // comfortably beyond the worst word latency

   // One operand word, plus a flag asking the driver to let the block drain
   // completely before this word is offered.
   typedef struct {
      logic [WIDTH-1:0] value;
      logic [WIDTH-1:0] modulus;
      bit               drain_first;
   } operand_word_type;

   typedef struct {
      logic [WIDTH-1:0] inverse;
      logic             has_inverse;
      logic [WIDTH-1:0] common_divisor;
   } inverse_result_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_start = 1'b0;
   logic [WIDTH-1:0] req_value = '0;
   logic [WIDTH-1:0] req_modulus = '0;
   logic             busy;
   logic             rsp_strobe;
   logic [WIDTH-1:0] rsp_inverse;
   logic             rsp_has_inverse;
   logic [WIDTH-1:0] rsp_common_divisor;

   operand_word_type   pending_operands[$];
   inverse_result_type awaited_inverses[$];

   int  mismatch_count = 0;
   int  idle_cycles = 0;
   bit  all_done = 1'b1;   // registered copy of "no result outstanding"

   // Driver bookkeeping, owned by the driver block alone.
   int  burst_left = 1;
   int  gap_left = 0;
   bit  draining = 1'b0;
   bit  word_taken;
   bit  offer_next;

   // Monitor scratch.
   inverse_result_type predicted;
   inverse_result_type oldest;

   modular_inverse #(
      .WIDTH(WIDTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_start         (req_start),
      .busy              (busy),
      .req_value         (req_value),
      .req_modulus       (req_modulus),
      .rsp_strobe        (rsp_strobe),
      .rsp_inverse       (rsp_inverse),
      .rsp_has_inverse   (rsp_has_inverse),
      .rsp_common_divisor(rsp_common_divisor)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Extended Euclid with the coefficient kept reduced modulo the modulus.
   // Intermediates are held at double width, so the product of a reduced
   // quotient and a reduced coefficient can never overflow.
   function automatic inverse_result_type euclid_inverse(logic [WIDTH-1:0] value,
                                                         logic [WIDTH-1:0] modulus);
      logic [2*WIDTH-1:0] m;
      logic [2*WIDTH-1:0] rem_prev;
      logic [2*WIDTH-1:0] rem_cur;
      logic [2*WIDTH-1:0] coef_prev;
      logic [2*WIDTH-1:0] coef_cur;
      logic [2*WIDTH-1:0] quot;
      logic [2*WIDTH-1:0] prod;
      logic [2*WIDTH-1:0] tmp;
      inverse_result_type res;
      m = {{WIDTH{1'b0}}, modulus};
      // A zero modulus has no inverse; the divisor is then the value itself.
      if (m == 0) begin
         res.inverse = '0;
         res.has_inverse = 1'b0;
         res.common_divisor = value;
         return res;
      end
      rem_prev = m;
      rem_cur = {{WIDTH{1'b0}}, value} % m;
      coef_prev = '0;
      coef_cur = 1 % m;
      while (rem_cur != 0) begin
         quot = rem_prev / rem_cur;
         tmp = rem_prev - quot * rem_cur;
         rem_prev = rem_cur;
         rem_cur = tmp;
         prod = ((quot % m) * coef_cur) % m;
         tmp = (coef_prev >= prod) ? coef_prev - prod : coef_prev + (m - prod);
         coef_prev = coef_cur;
         coef_cur = tmp;
      end
      // A unit modulus ends with divisor 1 and coefficient 0, which is correct.
      res.has_inverse = (rem_prev == 1);
      res.inverse = res.has_inverse ? coef_prev[WIDTH-1:0] : '0;
      res.common_divisor = rem_prev[WIDTH-1:0];
      return res;
   endfunction

   task automatic queue_operands(logic [WIDTH-1:0] value, logic [WIDTH-1:0] modulus,
                                 bit drain_first);
      operand_word_type w;
      w.value = value;
      w.modulus = modulus;
      w.drain_first = drain_first;
      pending_operands.push_back(w);
   endtask

   // Draws one random operand word from a mix of populations, so that coprime
   // pairs, shared factors, exact multiples and the degenerate moduli all turn
   // up regularly rather than by luck.
   task automatic queue_random_operands();
      logic [WIDTH-1:0] v;
      logic [WIDTH-1:0] m;
      logic [WIDTH-1:0] f;
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            v = $urandom;
            m = $urandom;
         end
         3: begin
            v = $urandom;
            m = $urandom_range(2, 300);
         end
         4: begin
            m = $urandom_range(2, 65535);
            v = m * $urandom_range(0, 65535);
         end
         5: begin
            f = $urandom_range(2, 97);
            v = f * $urandom_range(1, 1 << 24);
            m = f * $urandom_range(1, 1 << 24);
         end
         6: begin
            v = $urandom;
            m = $urandom_range(0, 1);
         end
         7: begin
            v = $urandom_range(0, 3);
            m = $urandom;
         end
         default: begin
            v = $urandom;
            m = $urandom | 1;
         end
      endcase
      queue_operands(v, m, $urandom_range(0, 79) == 0);
   endtask

   // Stimulus, reset and the end of the run.
   initial begin
      // Zero modulus: no inverse, the divisor is the value (zero when both are).
      queue_operands(32'd0, 32'd0, 1'b0);
      queue_operands(32'd5, 32'd0, 1'b0);
      queue_operands(32'hFFFF_FFFF, 32'd0, 1'b0);
      // Unit modulus: an inverse exists and it is zero.
      queue_operands(32'd0, 32'd1, 1'b0);
      queue_operands(32'hFFFF_FFFF, 32'd1, 1'b0);
      // Value a multiple of the modulus, including zero and the modulus itself.
      queue_operands(32'd0, 32'd7, 1'b0);
      queue_operands(32'd21, 32'd7, 1'b0);
      queue_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      queue_operands(32'hFFFF_FFFE, 32'd2, 1'b0);
      // Shared factor without being a multiple.
      queue_operands(32'd6, 32'd4, 1'b0);
      // Small coprime pairs, value below and above the modulus.
      queue_operands(32'd3, 32'd7, 1'b0);
      queue_operands(32'd100, 32'd7, 1'b0);
      queue_operands(32'd1, 32'd2, 1'b0);
      // Let the block fall completely idle once before continuing.
      queue_operands(32'd1, 32'hFFFF_FFFF, 1'b1);
      queue_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0);
      queue_operands(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
      queue_operands(32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
      queue_operands(32'd2, 32'd4294967291, 1'b0);
      // Consecutive Fibonacci numbers give the longest chain of Euclid steps.
      queue_operands(32'd2971215073, 32'd1836311903, 1'b0);
      queue_operands(32'd1836311903, 32'd2971215073, 1'b0);
      queue_operands(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
      queue_operands(32'h5555_5555, 32'hAAAA_AAAB, 1'b0);
      repeat (RANDOM_WORDS) queue_random_operands();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Sampled on the falling edge so that both clocked blocks have settled.
      do @(negedge clock);
      while (pending_operands.size() != 0 || req_start || !all_done);
      // Any stray strobe after the last expected word is caught in this window.
      repeat (SETTLE_WAIT) @(negedge clock);

      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Driver. A word stays on the req_ ports until the block takes it. Between
   // words it counts down the gap at the end of each burst, and for a word marked
   // to drain first it holds off until every outstanding result has come back.
   always @(posedge clock) begin
      if (reset) begin
         req_start <= 1'b0;
      end else begin
         word_taken = req_start && !busy;
         offer_next = 1'b0;
         if (word_taken) begin
            void'(pending_operands.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               case ($urandom_range(0, 2))
                  0: gap_left = 0;
                  1: gap_left = $urandom_range(1, 8);
                  default: gap_left = $urandom_range(20, 150);
               endcase
            end
         end
         if (req_start && !word_taken) begin
            // The current word is still waiting; leave the ports alone.
            offer_next = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
         end else if (draining) begin
            // all_done is registered, so it already reflects the last taken word.
            if (all_done)
               draining = 1'b0;
         end else if (pending_operands.size() != 0) begin
            if (pending_operands[0].drain_first) begin
               pending_operands[0].drain_first = 1'b0;
               draining = 1'b1;
            end else begin
               offer_next = 1'b1;
            end
         end
         req_start <= offer_next;
         if (offer_next && !req_start || word_taken && offer_next) begin
            req_value <= pending_operands[0].value;
            req_modulus <= pending_operands[0].modulus;
         end
      end
   end

   // Monitor. A strobed result belongs to a word taken at an earlier edge, so it
   // is checked before a word taken at this same edge is predicted.
   always @(posedge clock) begin
      if (reset) begin
         all_done <= 1'b1;
      end else begin
         if (rsp_strobe) begin
            if (awaited_inverses.size() == 0) begin
               mismatch_count++;
               $display("%0t: result word with none outstanding, inverse %h", $time,
                        rsp_inverse);
            end else begin
               oldest = awaited_inverses.pop_front();
               if (rsp_inverse !== oldest.inverse) begin
                  mismatch_count++;
                  $display("%0t: inverse expected %h, got %h", $time,
                           oldest.inverse, rsp_inverse);
               end
               if (rsp_has_inverse !== oldest.has_inverse) begin
                  mismatch_count++;
                  $display("%0t: has_inverse expected %b, got %b", $time,
                           oldest.has_inverse, rsp_has_inverse);
               end
               if (rsp_common_divisor !== oldest.common_divisor) begin
                  mismatch_count++;
                  $display("%0t: common_divisor expected %h, got %h", $time,
                           oldest.common_divisor, rsp_common_divisor);
               end
            end
         end
         if (req_start && !busy) begin
            predicted = euclid_inverse(req_value, req_modulus);
            awaited_inverses.push_back(predicted);
         end
         all_done <= (awaited_inverses.size() == 0);
      end
   end

   // Watchdog: a long stretch with neither a word taken nor a result given
   // means the block has hung.
   always @(posedge clock) begin
      if (reset || (req_start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Leftover expectations at the end are caught by the end-of-run wait, which
   // never completes while all_done is low, so the watchdog reports them.

endmodule

// ===== sim.f =====
design/modinv_pkg.sv
design/modinv_ctrl.sv
design/modinv_datapath.sv
design/modular_inverse.sv
verif/modular_inverse_test.sv
